>>> hw/rtl/pidf_pkg.sv
// pidf_pkg: shared types, constants and microcode table of the speed-loop pid
// control word layout and the read-only step program used by pidf_seq
// depends on nothing
`timescale 1ns / 1ps

package pidf_pkg;

  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int ALPHA_W   = 9;
  localparam int LIMIT_W   = 15;
  localparam int OPB_W     = GAIN_W + 1;
  localparam int STEP_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd179;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd500;

  // multiplier operands for f and d are held within +/- 2^46
  localparam logic signed [63:0] OPERAND_LIMIT = 64'sd70368744177664;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;

  typedef enum logic [1:0] {
    OPA_D_RAW,
    OPA_F_LIM,
    OPA_D_LIM,
    OPA_INT
  } op_a_t;

  typedef enum logic [1:0] {
    OPB_ALPHA,
    OPB_GP,
    OPB_GD,
    OPB_GI
  } op_b_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_WAIT_OUT
  } cond_t;

  typedef struct packed {
    op_a_t   op_a;
    op_b_t   op_b;
    acc_op_t acc_op;
    logic    ld_in;
    logic    ld_f;
    logic    ld_int;
    logic    emit;
    cond_t   cond;
  } ctrl_t;

  // step program: capture, alpha*d, filter, p term, d term, i term, sum, output
  function automatic ctrl_t ucode_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      3'd0: w = '{op_a: OPA_D_RAW, op_b: OPB_ALPHA, acc_op: ACC_HOLD, ld_in: 1'b1,
                  ld_f: 1'b0, ld_int: 1'b0, emit: 1'b0, cond: COND_WAIT_IN};
      3'd1: w = '{op_a: OPA_D_RAW, op_b: OPB_ALPHA, acc_op: ACC_HOLD, ld_in: 1'b0,
                  ld_f: 1'b0, ld_int: 1'b0, emit: 1'b0, cond: COND_NEXT};
      3'd2: w = '{op_a: OPA_D_RAW, op_b: OPB_ALPHA, acc_op: ACC_HOLD, ld_in: 1'b0,
                  ld_f: 1'b1, ld_int: 1'b0, emit: 1'b0, cond: COND_NEXT};
      3'd3: w = '{op_a: OPA_F_LIM, op_b: OPB_GP, acc_op: ACC_HOLD, ld_in: 1'b0,
                  ld_f: 1'b0, ld_int: 1'b1, emit: 1'b0, cond: COND_NEXT};
      3'd4: w = '{op_a: OPA_D_LIM, op_b: OPB_GD, acc_op: ACC_LOAD, ld_in: 1'b0,
                  ld_f: 1'b0, ld_int: 1'b0, emit: 1'b0, cond: COND_NEXT};
      3'd5: w = '{op_a: OPA_INT, op_b: OPB_GI, acc_op: ACC_ADD, ld_in: 1'b0,
                  ld_f: 1'b0, ld_int: 1'b0, emit: 1'b0, cond: COND_NEXT};
      3'd6: w = '{op_a: OPA_INT, op_b: OPB_GI, acc_op: ACC_ADD, ld_in: 1'b0,
                  ld_f: 1'b0, ld_int: 1'b0, emit: 1'b0, cond: COND_NEXT};
      3'd7: w = '{op_a: OPA_INT, op_b: OPB_GI, acc_op: ACC_HOLD, ld_in: 1'b0,
                  ld_f: 1'b0, ld_int: 1'b0, emit: 1'b1, cond: COND_WAIT_OUT};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/pidf_seq.sv
// pidf_seq: step counter and microcode lookup for the speed-loop pid
// holds on the input and output handshakes, gates load and emit strobes
// depends on pidf_pkg
`timescale 1ns / 1ps

module pidf_seq import pidf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_busy,
  output logic  in_ready,
  output ctrl_t ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_t             word;
  logic              advance;

  assign word = ucode_word(step);

  always_comb begin
    unique case (word.cond)
      COND_NEXT:     advance = 1'b1;
      COND_WAIT_IN:  advance = in_valid;
      COND_WAIT_OUT: advance = !out_busy;
      default:       advance = 1'b1;
    endcase
    // last step wraps back to the capture step
    step_next = advance ? step + STEP_W'(1) : step;
  end

  always_comb begin
    ctrl       = word;
    ctrl.ld_in = word.ld_in & in_valid;
    ctrl.emit  = word.emit & !out_busy;
    // no transaction is taken while reset holds the step counter
    in_ready   = word.ld_in & !rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> hw/rtl/pid_speed_filtered_clamped.sv
// pid_speed_filtered_clamped: speed-loop pid with filtered error and clamped integral
// one shared multiplier and accumulator driven by the pidf_seq microcode
// depends on pidf_pkg and pidf_seq
`timescale 1ns / 1ps

// Usage
//   s_tvalid/s_tready/s_tdata carry one sample: target and measured speed.
//   m_tvalid/m_tready/m_tdata/m_tuser return one result per sample: the drive
//   value and a flag set when it was clipped to the signed range.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the gains, the filter weight
//   and the integral limit; cfg_ready is high outside reset. Write only when idle.
// Sequence
//   a result is valid once its input has run through the step program; the next
//   sample is taken only when the program is back at its capture step. The pace
//   is set by the single shared multiplier, which the eight-step program uses
//   for alpha*d and the three gain products in turn.
// Reset
//   rst clears the filter and integral state, loads the register defaults
//   (gains 0, alpha 179, limit 500) and empties the output register.
// Stalls
//   a finished result waits in the output register; the block still takes
//   the next sample and computes it, then holds on its last step until the
//   output register frees.

module pid_speed_filtered_clamped import pidf_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // target_speed, measured_speed
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // drive
  output logic [((DATA_WIDTH+7)/8)*8-1:0]       m_tdata,
  // saturated
  output logic                                  m_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_W-1:0]                      cfg_data
);

  localparam int OUT_TW = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int EW     = DATA_WIDTH + FRAC_BITS + 1;       // error and filtered error
  localparam int DW_D   = EW + 1;                           // difference term
  localparam int IW     = FRAC_BITS + LIMIT_W + 1;          // clamped integral
  localparam int MAW    = (DW_D > IW) ? DW_D : IW;          // multiplier operand a
  localparam int PW     = MAW + OPB_W;                      // product
  localparam int ACW    = PW + 2;                           // sum of three products
  localparam int SW     = ((IW > EW) ? IW : EW) + 1;        // integral before clamp
  localparam int SH     = FRAC_BITS + GAIN_FRAC;

  // configuration registers
  logic signed [GAIN_W-1:0]  gain_p;
  logic signed [GAIN_W-1:0]  gain_d;
  logic signed [GAIN_W-1:0]  gain_i;
  logic        [ALPHA_W-1:0] filter_alpha;
  logic        [LIMIT_W-1:0] integral_limit;

  // loop state
  logic signed [EW-1:0]      filt;
  logic signed [IW-1:0]      integral;

  // datapath registers
  logic signed [EW-1:0]      err;
  logic signed [DW_D-1:0]    diff;
  logic signed [PW-1:0]      prod;
  logic signed [ACW-1:0]     acc;
  logic [DATA_WIDTH-1:0]     drive;
  logic                      saturated;

  ctrl_t ctrl;
  logic  out_busy;
  logic  cfg_wr;

  logic signed [DATA_WIDTH-1:0] target_speed;
  logic signed [DATA_WIDTH-1:0] measured_speed;
  logic signed [DATA_WIDTH:0]   speed_diff;
  logic signed [EW-1:0]         err_in;
  logic signed [DW_D-1:0]       diff_in;

  logic        [ALPHA_W-1:0]    alpha_eff;
  logic signed [63:0]           f64;
  logic signed [63:0]           d64;
  logic signed [63:0]           f_cl;
  logic signed [63:0]           d_cl;
  logic signed [MAW-1:0]        mul_a;
  logic signed [OPB_W-1:0]      mul_b;

  logic signed [PW:0]           neg_prod;
  logic signed [PW:0]           f_wide;
  logic signed [EW-1:0]         filt_next;

  logic signed [SW-1:0]         int_sum;
  logic signed [SW-1:0]         lim_s;
  logic signed [SW-1:0]         int_clamped;
  logic signed [IW-1:0]         integral_next;

  logic signed [ACW-1:0]        acc_next;
  logic signed [ACW-1:0]        trunc_bias;
  logic signed [ACW-1:0]        q;
  logic                         q_fits;
  logic [DATA_WIDTH-1:0]        drive_next;
  logic                         sat_next;

  pidf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_busy (out_busy),
    .in_ready (s_tready),
    .ctrl     (ctrl)
  );

  assign out_busy  = m_tvalid && !m_tready;
  assign cfg_ready = !rst;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign m_tdata   = OUT_TW'(drive);
  assign m_tuser   = saturated;

  // sample capture: e in fixed point, d against the previous filtered error
  assign target_speed   = s_tdata[DATA_WIDTH-1:0];
  assign measured_speed = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
  assign speed_diff     = (DATA_WIDTH+1)'(target_speed) - (DATA_WIDTH+1)'(measured_speed);
  assign err_in         = {speed_diff, {FRAC_BITS{1'b0}}};
  assign diff_in        = DW_D'(err_in) - DW_D'(filt);

  // operand selection for the shared multiplier
  assign alpha_eff = (filter_alpha > ALPHA_ONE) ? ALPHA_ONE : filter_alpha;
  assign f64       = 64'(filt);
  assign d64       = 64'(diff);
  assign f_cl      = (f64 > OPERAND_LIMIT) ? OPERAND_LIMIT :
                     ((f64 < -OPERAND_LIMIT) ? -OPERAND_LIMIT : f64);
  assign d_cl      = (d64 > OPERAND_LIMIT) ? OPERAND_LIMIT :
                     ((d64 < -OPERAND_LIMIT) ? -OPERAND_LIMIT : d64);

  always_comb begin
    unique case (ctrl.op_a)
      OPA_D_RAW: mul_a = MAW'(diff);
      OPA_F_LIM: mul_a = f_cl[MAW-1:0];
      OPA_D_LIM: mul_a = d_cl[MAW-1:0];
      OPA_INT:   mul_a = MAW'(integral);
    endcase
    unique case (ctrl.op_b)
      OPB_ALPHA: mul_b = OPB_W'(alpha_eff);
      OPB_GP:    mul_b = OPB_W'(gain_p);
      OPB_GD:    mul_b = OPB_W'(gain_d);
      OPB_GI:    mul_b = OPB_W'(gain_i);
    endcase
  end

  // f = e + floor(-alpha*d / 256), same as the weighted mix of e and previous f
  assign neg_prod  = -(PW+1)'(prod);
  assign f_wide    = (PW+1)'(err) + (neg_prod >>> 8);
  assign filt_next = f_wide[EW-1:0];

  // integral update with the symmetric clamp
  assign int_sum       = SW'(integral) + SW'(filt);
  assign lim_s         = SW'({1'b0, integral_limit, {FRAC_BITS{1'b0}}});
  assign int_clamped   = (int_sum > lim_s) ? lim_s :
                         ((int_sum < -lim_s) ? -lim_s : int_sum);
  assign integral_next = int_clamped[IW-1:0];

  always_comb begin
    unique case (ctrl.acc_op)
      ACC_LOAD: acc_next = ACW'(prod);
      ACC_ADD:  acc_next = acc + ACW'(prod);
      default:  acc_next = acc;
    endcase
  end

  // truncate toward zero, then saturate to the output width
  assign trunc_bias = {{(ACW-SH){1'b0}}, {SH{acc[ACW-1]}}};
  assign q          = (acc + trunc_bias) >>> SH;
  assign q_fits     = (&q[ACW-1:DATA_WIDTH-1]) || !(|q[ACW-1:DATA_WIDTH-1]);
  assign sat_next   = !q_fits;
  assign drive_next = q_fits ? q[DATA_WIDTH-1:0] :
                      {q[ACW-1], {(DATA_WIDTH-1){!q[ACW-1]}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_d         <= '0;
      gain_i         <= '0;
      filter_alpha   <= ALPHA_RESET;
      integral_limit <= LIMIT_RESET;
      filt           <= '0;
      integral       <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_GAIN_P:         gain_p         <= cfg_data;
          REG_GAIN_D:         gain_d         <= cfg_data;
          REG_GAIN_I:         gain_i         <= cfg_data;
          REG_FILTER_ALPHA:   filter_alpha   <= cfg_data[ALPHA_W-1:0];
          REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (ctrl.ld_f) begin
        filt <= filt_next;
      end
      if (ctrl.ld_int) begin
        integral <= integral_next;
      end
      if (ctrl.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    acc  <= acc_next;
    if (ctrl.ld_in) begin
      err  <= err_in;
      diff <= diff_in;
    end
    if (ctrl.emit) begin
      drive     <= drive_next;
      saturated <= sat_next;
    end
  end

`ifndef SYNTHESIS
  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> !(m_tvalid && !m_tready))
    else $error("result emitted over an untaken one");

  a_integral_in_limit: assert property (@(posedge clk) disable iff (rst)
    (ctrl.ld_int && !cfg_wr) |=> (SW'(integral) <= lim_s) && (SW'(integral) >= -lim_s))
    else $error("integral outside its clamp");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second sample taken while one is in progress");
`endif

endmodule

>>> test/pid_speed_filtered_clamped_tb.sv
`timescale 1ns / 1ps
// pid_speed_filtered_clamped_tb: self-checking bench for the filtered speed-loop pid
// mirrors the filter, integral clamp and output saturation to check every drive value
// depends on pidf_pkg and pid_speed_filtered_clamped

module pid_speed_filtered_clamped_tb;
  import pidf_pkg::*;

  localparam int DW         = 16;
  localparam int FRAC       = 8;
  localparam int ALPHA_FRAC = 8;
  localparam int GAP_PCT    = 7;
  localparam longint DRIVE_MAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint DRIVE_MIN = -DRIVE_MAX - 1;
  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic                 saturated;
  } drive_rec_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [2*DW-1:0]      s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [DW-1:0]        m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  logic calm        = 1'b0;
  int   errors      = 0;
  int   n_samples   = 0;
  int   n_checked   = 0;
  int   n_saturated = 0;

  // shadow copy of the registers and the loop state
  logic signed [GAIN_W-1:0] kp = '0;
  logic signed [GAIN_W-1:0] kd = '0;
  logic signed [GAIN_W-1:0] ki = '0;
  logic [ALPHA_W-1:0]       alpha_w   = ALPHA_RESET;
  logic [LIMIT_W-1:0]       int_limit = LIMIT_RESET;
  longint                   last_filt = 0;
  longint                   integ_acc = 0;

  drive_rec_t pending_drive[$];

  pid_speed_filtered_clamped #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #20000000;
    $display("pid_speed_filtered_clamped_tb: FAIL");
    $finish;
  end

  function automatic longint bound_operand(input longint v);
    if (v > OPERAND_LIMIT) return OPERAND_LIMIT;
    if (v < -OPERAND_LIMIT) return -OPERAND_LIMIT;
    return v;
  endfunction

  // one control-loop update: filter, clamped integral, gains, truncate, saturate
  function automatic drive_rec_t pid_update(input logic signed [DW-1:0] tgt,
                                            input logic signed [DW-1:0] meas);
    longint     err, diff, filt, lim, weight, acc, val;
    drive_rec_t r;
    weight = (alpha_w > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_w);
    err    = (longint'(tgt) - longint'(meas)) * (longint'(1) << FRAC);
    diff   = err - last_filt;
    filt   = ((longint'(ALPHA_ONE) - weight) * err + weight * last_filt) >>> ALPHA_FRAC;
    lim    = longint'(int_limit) * (longint'(1) << FRAC);
    integ_acc = integ_acc + filt;
    if (integ_acc > lim) integ_acc = lim;
    else if (integ_acc < -lim) integ_acc = -lim;
    last_filt = filt;
    acc = longint'(kp) * bound_operand(filt) + longint'(kd) * bound_operand(diff)
        + longint'(ki) * integ_acc;
    // truncate toward zero, not toward minus infinity
    val = (acc < 0) ? -((-acc) >>> (FRAC + GAIN_FRAC)) : (acc >>> (FRAC + GAIN_FRAC));
    r.saturated = 1'b0;
    if (val > DRIVE_MAX) begin
      val = DRIVE_MAX;
      r.saturated = 1'b1;
    end
    if (val < DRIVE_MIN) begin
      val = DRIVE_MIN;
      r.saturated = 1'b1;
    end
    r.drive = val[DW-1:0];
    return r;
  endfunction

  // output side: random back-pressure, none while calm
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= GAP_PCT);
  end

  always @(posedge clk) begin
    drive_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_drive.size() == 0) begin
        $error("drive transaction with nothing expected: drive %0d saturated %0b",
               $signed(m_tdata), m_tuser);
        errors++;
      end else begin
        want = pending_drive.pop_front();
        n_checked++;
        if (want.saturated) n_saturated++;
        if (m_tdata !== want.drive) begin
          $error("drive: expected %0d, got %0d", want.drive, $signed(m_tdata));
          errors++;
        end
        if (m_tuser !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, m_tuser);
          errors++;
        end
      end
    end
  end

  // valid is left high so back-to-back samples need no drop in between
  task automatic send_sample(input logic signed [DW-1:0] tgt,
                             input logic signed [DW-1:0] meas);
    if (!calm && $urandom_range(99) < GAP_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {meas, tgt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_drive.push_back(pid_update(tgt, meas));
    n_samples++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GAIN_P:         kp = data;
      REG_GAIN_D:         kd = data;
      REG_GAIN_I:         ki = data;
      REG_FILTER_ALPHA:   alpha_w = data[ALPHA_W-1:0];
      REG_INTEGRAL_LIMIT: int_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // unused upper bits of the narrow registers carry junk
  task automatic load_settings(input logic signed [GAIN_W-1:0] gp,
                               input logic signed [GAIN_W-1:0] gd,
                               input logic signed [GAIN_W-1:0] gi,
                               input logic [ALPHA_W-1:0] alpha,
                               input logic [LIMIT_W-1:0] limit);
    wait_idle();
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_FILTER_ALPHA, {7'($urandom), alpha});
    write_reg(REG_INTEGRAL_LIMIT, {1'($urandom), limit});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [GAIN_W-1:0] rand_gain();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(2048) - 1024);
    endcase
  endfunction

  function automatic logic [ALPHA_W-1:0] rand_alpha();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALPHA_ONE;
      2:       return ALPHA_RESET;
      3:       return ALPHA_W'($urandom_range(511, 257));
      default: return ALPHA_W'($urandom_range(256));
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] rand_limit();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 15'h7FFF;
      2, 3:    return LIMIT_W'($urandom);
      default: return LIMIT_W'($urandom_range(2000));
    endcase
  endfunction

  // gains are zero out of reset, but the filter and integral still move
  task automatic test_reset_defaults();
    send_sample(16'sd100, 16'sd40);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
  endtask

  task automatic test_saturation();
    load_settings(16'h7FFF, 16'h8000, 16'h7FFF, '0, 15'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    load_settings(16'h8000, 16'h7FFF, 16'h8000, ALPHA_RESET, 15'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
  endtask

  // tiny gain so small negative sums show rounding toward zero
  task automatic test_truncation();
    load_settings(16'sd1, '0, '0, '0, LIMIT_RESET);
    send_sample(16'sd0, 16'sd1);
    send_sample(16'sd1, 16'sd0);
    send_sample(16'sd0, 16'sd257);
    send_sample(16'sd257, 16'sd0);
  endtask

  task automatic test_filter_weight();
    load_settings(16'sd256, 16'sd256, '0, ALPHA_ONE, LIMIT_RESET);
    send_sample(16'sd1000, 16'sd0);
    send_sample(16'sd0, 16'sd1000);
    wait_idle();
    write_reg(REG_SPARE, 16'hFFFF);
    // weights beyond one behave as one
    load_settings(16'sd256, 16'sd256, '0, 9'd511, LIMIT_RESET);
    send_sample(16'sd1000, 16'sd0);
    send_sample(-16'sd700, 16'sd20);
    load_settings(16'sd256, 16'sd256, '0, 9'd257, LIMIT_RESET);
    send_sample(16'sd50, 16'sd0);
    load_settings(-16'sd256, 16'sd512, '0, 9'd1, LIMIT_RESET);
    send_sample(16'sd300, -16'sd300);
    send_sample(-16'sd300, 16'sd300);
  endtask

  task automatic test_integral_clamp();
    load_settings('0, '0, 16'sd256, '0, '0);
    send_sample(16'sd300, 16'sd0);
    send_sample(-16'sd300, 16'sd0);
    load_settings('0, '0, 16'h7FFF, '0, 15'd3);
    send_sample(16'sd100, 16'sd0);
    send_sample(16'sd100, 16'sd0);
    send_sample(-16'sd100, 16'sd0);
    load_settings('0, '0, 16'sd256, '0, 15'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h7FFF, 16'h8000);
  endtask

  // mostly speeds near each other so the loop stays out of saturation
  task automatic test_random_loop();
    logic signed [DW-1:0] tgt, meas;
    for (int phase = 0; phase < 11; phase++) begin
      load_settings(rand_gain(), rand_gain(), rand_gain(), rand_alpha(), rand_limit());
      calm = (phase == 4);
      for (int k = 0; k < 150; k++) begin
        if ($urandom_range(9) < 3) begin
          tgt  = DW'($urandom);
          meas = DW'($urandom);
        end else begin
          tgt  = DW'($urandom_range(4000) - 2000);
          meas = DW'(tgt + $urandom_range(200) - 100);
        end
        send_sample(tgt, meas);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_saturation();
    test_truncation();
    test_filter_weight();
    test_integral_clamp();
    test_random_loop();
    wait_idle();
    repeat (16) @(posedge clk);
    $display("covered %0d samples over directed and random gain/filter/limit settings",
             n_samples);
    $display("checked %0d drive results, %0d of them clipped", n_checked, n_saturated);
    if (errors == 0) begin
      $display("pid_speed_filtered_clamped_tb: PASS");
    end else begin
      $display("pid_speed_filtered_clamped_tb: FAIL");
    end
    $finish;
  end

endmodule
